[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[hw/rtl/chc_pkg.sv]
package chc_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_INSERT  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_PURGE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_MISS     = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] setting;
    logic [31:0] user;
    logic [15:0] handle;
  } chc_entry_t;

endpackage

[hw/rtl/chc_store.sv]
module chc_store #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IW      = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IW-1:0]       raddr_i,
  output chc_pkg::chc_entry_t rdata_o,
  input  logic                we_i,
  input  logic [IW-1:0]       waddr_i,
  input  chc_pkg::chc_entry_t wdata_i
);
  import chc_pkg::*;

  chc_entry_t         mem_q [ENTRIES];
  chc_entry_t         rent_q;
  logic               rvld_q;
  logic [ENTRIES-1:0] vld_q;

  // entries never written read as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[raddr_i];
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rent_q <= mem_q[raddr_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rvld_q ? rent_q : '0;

endmodule

[hw/rtl/credential_handle_cache.sv]
// Channel  | Handshake        | Word
// ---------+------------------+-----------------------------------------------
// request  | start, busy      | operation_i, setting_id_i, user_id_i, handle_in_i
// result   | done_o (strobe)  | status_o, handle_out_o, evicted_handle_o, slot_o
//
// One request at a time; busy is high from acceptance until the result strobe.
// Lookup, release and purge walk the entry memory one entry a cycle; lookup
// and release stop early on a hit, while purge always walks every entry.
// Insert probes the lock bits one a cycle from the victim pointer, then writes
// the victim and locks it, or reports full when every probed entry is locked.
// Reset clears all entries to null and free. The receiver cannot stall: the
// done_o strobe is high for one cycle only; a new request may start in that cycle.
`include "assert_macros.svh"

module credential_handle_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [15:0] setting_id_i,
  input  logic [31:0] user_id_i,
  input  logic [15:0] handle_in_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] handle_out_o,
  output logic [15:0] evicted_handle_o,
  output logic [3:0]  slot_o
);
  import chc_pkg::*;

  localparam int unsigned IW       = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST   = IW'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_INS   = 2'd2;
  localparam logic [1:0] S_INSWR = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      ptr_q, ptr_d;
  logic [IW-1:0]      vict_q, vict_d;
  logic [ENTRIES-1:0] lock_q, lock_d;

  logic [1:0]  op_q;
  logic [15:0] sid_q;
  logic [31:0] uid_q;
  logic [15:0] hin_q;

  logic        done_q, done_d;
  logic [1:0]  status_q, status_d;
  logic [15:0] hout_q, hout_d;
  logic [15:0] ev_q, ev_d;
  logic [3:0]  slot_q, slot_d;

  logic          accept;
  logic [IW-1:0] raddr;
  chc_entry_t    rdata;
  logic          we;
  logic [IW-1:0] waddr;
  chc_entry_t    wdata;
  logic [IW-1:0] idx_nxt, ptr_nxt;
  logic          lk_hit, rl_hit, pg_hit;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign idx_nxt = (idx_q == LAST) ? '0 : idx_q + 1'b1;
  assign ptr_nxt = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;

  assign lk_hit = (sid_q != 16'd0) && (rdata.setting == sid_q) && (rdata.user == uid_q)
                  && !lock_q[idx_q] && (rdata.handle != 16'd0);
  assign rl_hit = (hin_q != 16'd0) && (rdata.handle == hin_q);
  assign pg_hit = (sid_q != 16'd0) && (rdata.setting == sid_q);

  chc_store #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    ptr_d    = ptr_q;
    vict_d   = vict_q;
    lock_d   = lock_q;
    done_d   = 1'b0;
    status_d = status_q;
    hout_d   = hout_q;
    ev_d     = ev_q;
    slot_d   = slot_q;
    raddr    = '0;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = rdata;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          state_d = (operation_i == OP_INSERT) ? S_INS : S_SCAN;
        end
      end
      S_SCAN: begin
        raddr = idx_nxt;
        case (op_q)
          OP_LOOKUP: begin
            if (lk_hit) begin
              lock_d[idx_q] = 1'b1;
              done_d   = 1'b1;
              status_d = ST_DONE;
              hout_d   = rdata.handle;
              ev_d     = 16'd0;
              slot_d   = 4'(idx_q);
              state_d  = S_IDLE;
            end else if (idx_q == LAST) begin
              done_d   = 1'b1;
              status_d = ST_MISS;
              hout_d   = 16'd0;
              ev_d     = 16'd0;
              slot_d   = 4'd0;
              state_d  = S_IDLE;
            end
          end
          OP_RELEASE: begin
            if (rl_hit) begin
              lock_d[idx_q] = 1'b0;
              done_d   = 1'b1;
              status_d = ST_DONE;
              hout_d   = 16'd0;
              ev_d     = 16'd0;
              slot_d   = 4'(idx_q);
              state_d  = S_IDLE;
            end else if (idx_q == LAST) begin
              done_d   = 1'b1;
              status_d = ST_NOTFOUND;
              hout_d   = 16'd0;
              ev_d     = 16'd0;
              slot_d   = 4'd0;
              state_d  = S_IDLE;
            end
          end
          default: begin
            if (pg_hit) begin
              we            = 1'b1;
              wdata.setting = 16'd0;
              lock_d[idx_q] = 1'b0;
            end
            if (idx_q == LAST) begin
              done_d   = 1'b1;
              status_d = ST_DONE;
              hout_d   = 16'd0;
              ev_d     = 16'd0;
              slot_d   = 4'd0;
              state_d  = S_IDLE;
            end
          end
        endcase
        idx_d = idx_nxt;
      end
      S_INS: begin
        raddr = ptr_q;
        ptr_d = ptr_nxt;
        idx_d = idx_nxt;
        if (!lock_q[ptr_q]) begin
          vict_d  = ptr_q;
          state_d = S_INSWR;
        end else if (idx_q == LAST) begin
          done_d   = 1'b1;
          status_d = ST_FULL;
          hout_d   = 16'd0;
          ev_d     = 16'd0;
          slot_d   = 4'd0;
          state_d  = S_IDLE;
        end
      end
      S_INSWR: begin
        we             = 1'b1;
        waddr          = vict_q;
        wdata.setting  = sid_q;
        wdata.user     = uid_q;
        wdata.handle   = hin_q;
        lock_d[vict_q] = 1'b1;
        done_d         = 1'b1;
        status_d       = ST_DONE;
        hout_d         = 16'd0;
        ev_d           = rdata.handle;
        slot_d         = 4'(vict_q);
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      ptr_q   <= '0;
      vict_q  <= '0;
      lock_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ptr_q   <= ptr_d;
      vict_q  <= vict_d;
      lock_q  <= lock_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      sid_q <= setting_id_i;
      uid_q <= user_id_i;
      hin_q <= handle_in_i;
    end
    status_q <= status_d;
    hout_q   <= hout_d;
    ev_q     <= ev_d;
    slot_q   <= slot_d;
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign handle_out_o     = hout_q;
  assign evicted_handle_o = ev_q;
  assign slot_o           = slot_q;

  `ASSERT_NEVER(a_done_idle, clk_i, rst_ni, done_o && busy)
  `ASSERT_PROP(a_accept_busy, clk_i, rst_ni, accept |=> busy)
  `ASSERT_PROP(a_full_all_locked, clk_i, rst_ni, (done_o && (status_o == ST_FULL)) |-> (&lock_q))
  `ASSERT_PROP(a_insert_locks, clk_i, rst_ni, (state_q == S_INSWR) |=> lock_q[$past(vict_q)])

endmodule

[sim/chc_result_checker.sv]
`timescale 1ns / 1ps
module chc_result_checker #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  operation_i,
  input  logic [15:0] setting_id_i,
  input  logic [31:0] user_id_i,
  input  logic [15:0] handle_in_i,
  input  logic        done_i,
  input  logic [1:0]  status_i,
  input  logic [15:0] handle_out_i,
  input  logic [15:0] evicted_handle_i,
  input  logic [3:0]  slot_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          hits_o,
  output int          overflows_o
);
  import chc_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [15:0] handle;
    logic [15:0] evicted;
    logic [3:0]  slot;
  } cache_result_t;

  logic [15:0]   tag_setting [ENTRIES];
  logic [31:0]   tag_user    [ENTRIES];
  logic          lock_bit    [ENTRIES];
  logic [15:0]   held_handle [ENTRIES];
  int unsigned   next_victim;
  cache_result_t expected_results[$];

  function automatic cache_result_t apply_request(op_e op, logic [15:0] sid,
                                                  logic [31:0] uid, logic [15:0] hin);
    cache_result_t r;
    logic          found;
    int unsigned   v;
    int unsigned   probes;
    r.status  = ST_DONE;
    r.handle  = '0;
    r.evicted = '0;
    r.slot    = '0;
    found     = 1'b0;
    case (op)
      OP_LOOKUP: begin
        r.status = ST_MISS;
        if (sid != 16'd0) begin
          for (int k = 0; k < ENTRIES; k++) begin
            if (!found && tag_setting[k] == sid && tag_user[k] == uid &&
                !lock_bit[k] && held_handle[k] != 16'd0) begin
              found       = 1'b1;
              lock_bit[k] = 1'b1;
              r.status    = ST_DONE;
              r.handle    = held_handle[k];
              r.slot      = k[3:0];
            end
          end
        end
      end
      OP_INSERT: begin
        // round-robin probe, skipping locked entries
        v           = next_victim;
        next_victim = (v + 1) % ENTRIES;
        for (probes = 1; probes < ENTRIES && lock_bit[v]; probes++) begin
          v           = next_victim;
          next_victim = (v + 1) % ENTRIES;
        end
        if (lock_bit[v]) begin
          r.status = ST_FULL;
        end else begin
          r.evicted      = held_handle[v];
          r.slot         = v[3:0];
          lock_bit[v]    = 1'b1;
          held_handle[v] = hin;
          tag_user[v]    = uid;
          tag_setting[v] = sid;
        end
      end
      OP_RELEASE: begin
        r.status = ST_NOTFOUND;
        if (hin != 16'd0) begin
          for (int k = 0; k < ENTRIES; k++) begin
            if (!found && held_handle[k] == hin) begin
              found       = 1'b1;
              lock_bit[k] = 1'b0;
              r.status    = ST_DONE;
              r.slot      = k[3:0];
            end
          end
        end
      end
      default: begin
        if (sid != 16'd0) begin
          for (int k = 0; k < ENTRIES; k++) begin
            if (tag_setting[k] == sid) begin
              tag_setting[k] = '0;
              lock_bit[k]    = 1'b0;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < ENTRIES; k++) begin
        tag_setting[k] = '0;
        tag_user[k]    = '0;
        lock_bit[k]    = 1'b0;
        held_handle[k] = '0;
      end
      next_victim = 0;
      expected_results.delete();
      fail_count_o = 0;
      checked_o    = 0;
      hits_o       = 0;
      overflows_o  = 0;
      pending_o    = 0;
    end else begin
      if (done_i === 1'b1) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected: status %0d handle %h evicted %h slot %0d",
                   $time, status_i, handle_out_i, evicted_handle_i, slot_i);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          checked_o++;
          if (want.status == ST_DONE && want.handle != 16'd0) hits_o++;
          if (want.status == ST_FULL) overflows_o++;
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            fail_count_o++;
          end
          if (handle_out_i !== want.handle) begin
            $display("%0t: handle_out expected %h actual %h", $time, want.handle, handle_out_i);
            fail_count_o++;
          end
          if (evicted_handle_i !== want.evicted) begin
            $display("%0t: evicted_handle expected %h actual %h",
                     $time, want.evicted, evicted_handle_i);
            fail_count_o++;
          end
          if (slot_i !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, slot_i);
            fail_count_o++;
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        expected_results.push_back(apply_request(op_e'(operation_i), setting_id_i,
                                                 user_id_i, handle_in_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

[sim/tb_credential_handle_cache.sv]
`timescale 1ns / 1ps
module tb_credential_handle_cache;
  import chc_pkg::*;

  localparam int unsigned ENTRIES         = 16;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned DRAIN_CYCLES    = 2 * ENTRIES + 8;
  localparam int unsigned ITEMS_PER_PHASE = 616;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic [1:0]  operation_i = '0;
  logic [15:0] setting_id_i = '0;
  logic [31:0] user_id_i   = '0;
  logic [15:0] handle_in_i = '0;
  logic        busy;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] handle_out_o;
  logic [15:0] evicted_handle_o;
  logic [3:0]  slot_o;

  int          fail_count;
  int          pending;
  int          checked;
  int          hits;
  int          overflows;
  int          idle_pct    = 0;
  int          words_sent  = 0;
  int          cycles      = 0;
  chc_entry_t  recent_keys[$];

  credential_handle_cache #(.ENTRIES(ENTRIES)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .setting_id_i    (setting_id_i),
    .user_id_i       (user_id_i),
    .handle_in_i     (handle_in_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .handle_out_o    (handle_out_o),
    .evicted_handle_o(evicted_handle_o),
    .slot_o          (slot_o)
  );

  chc_result_checker #(.ENTRIES(ENTRIES)) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .operation_i     (operation_i),
    .setting_id_i    (setting_id_i),
    .user_id_i       (user_id_i),
    .handle_in_i     (handle_in_i),
    .done_i          (done_o),
    .status_i        (status_o),
    .handle_out_i    (handle_out_o),
    .evicted_handle_i(evicted_handle_o),
    .slot_i          (slot_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .hits_o          (hits),
    .overflows_o     (overflows)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [15:0] pick_setting();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return 16'($urandom_range(1, 4));
    if (roll < 88) return 16'd0;
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [31:0] pick_user();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return 32'($urandom_range(0, 3));
    if (roll < 88) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  function automatic logic [15:0] pick_handle();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return 16'($urandom_range(1, 48));
    if (roll < 85) return 16'd0;
    if (roll < 90) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  // called at a rising edge; returns at the edge that took the word or after a gap
  task automatic issue_request(op_e op, logic [15:0] sid, logic [31:0] uid,
                               logic [15:0] hin);
    chc_entry_t key;
    start        <= 1'b1;
    operation_i  <= op;
    setting_id_i <= sid;
    user_id_i    <= uid;
    handle_in_i  <= hin;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    words_sent++;
    if (op == OP_INSERT) begin
      key.setting = sid;
      key.user    = uid;
      key.handle  = hin;
      recent_keys.push_back(key);
      if (recent_keys.size() > 24) void'(recent_keys.pop_front());
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic run_phase(int pct);
    int         goal;
    int         roll;
    chc_entry_t key;
    idle_pct = pct;
    goal     = words_sent + ITEMS_PER_PHASE;
    while (words_sent < goal) begin
      roll = $urandom_range(99);
      if (recent_keys.size() > 0) begin
        key = recent_keys[$urandom_range(recent_keys.size() - 1)];
      end else begin
        key.setting = pick_setting();
        key.user    = pick_user();
        key.handle  = pick_handle();
      end
      if (roll < 55) begin
        // insert, then release and reclaim the same handle
        key.setting = pick_setting();
        key.user    = pick_user();
        key.handle  = pick_handle();
        issue_request(OP_INSERT, key.setting, key.user, key.handle);
        repeat ($urandom_range(0, 2)) begin
          issue_request(OP_RELEASE, pick_setting(), pick_user(), key.handle);
          issue_request(OP_LOOKUP, key.setting, key.user, pick_handle());
        end
        if ($urandom_range(1) == 1)
          issue_request(OP_RELEASE, pick_setting(), pick_user(), key.handle);
      end else if (roll < 70) begin
        repeat ($urandom_range(4, 18))
          issue_request(OP_INSERT, pick_setting(), pick_user(), pick_handle());
      end else if (roll < 80) begin
        issue_request(OP_LOOKUP, key.setting, key.user, pick_handle());
      end else if (roll < 88) begin
        issue_request(OP_RELEASE, pick_setting(), pick_user(), key.handle);
      end else if (roll < 93) begin
        issue_request(OP_PURGE, ($urandom_range(1) == 1) ? key.setting : pick_setting(),
                      pick_user(), pick_handle());
      end else begin
        issue_request(op_e'($urandom_range(3)), 16'($urandom_range(65535)), $urandom(),
                      16'($urandom_range(65535)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table and null keys
    issue_request(OP_LOOKUP, 16'd0, 32'd0, 16'd0);
    issue_request(OP_RELEASE, 16'd0, 32'd0, 16'd0);
    issue_request(OP_PURGE, 16'd0, 32'd0, 16'd0);
    // all-ones key and an all-null insert
    issue_request(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    issue_request(OP_INSERT, 16'd0, 32'd0, 16'd0);
    issue_request(OP_RELEASE, 16'd0, 32'd0, 16'hFFFF);
    issue_request(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 16'd0);
    issue_request(OP_LOOKUP, 16'd0, 32'd0, 16'hFFFF);
    issue_request(OP_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 16'd0);
    // lock every entry, then one insert too many
    for (int k = 0; k < ENTRIES - 1; k++)
      issue_request(OP_INSERT, 16'd1, 32'hA5A5_0000 + k, 16'(16'h0100 + k));
    issue_request(OP_PURGE, 16'd1, 32'd0, 16'd0);
    wait_until_drained();

    run_phase(29);
    wait_until_drained();
    run_phase(51);
    wait_until_drained();
    run_phase(0);
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d request words over %0d cycles, %0d result words checked",
             words_sent, cycles, checked);
    $display("%0d lookup hits and %0d table-full overflows seen", hits, overflows);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
